// File: hdl/lgts_pkg.sv
// ----------------------------------------------------------------------------
// lgts_pkg
// Shared types and constants of the Gibbs topic sampler: field widths,
// operation codes, register indexes, controller states, command and status.
// ----------------------------------------------------------------------------
package lgts_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned WORD_W     = 12;
  localparam int unsigned TOPIC_W    = 6;
  localparam int unsigned PHI_W      = 16;
  localparam int unsigned DRAW_W     = 16;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned NTOP_W     = 7;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MCNT_W     = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd128;
  localparam logic [NTOP_W-1:0]  NTOP_RESET  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOPICS = 8'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_ADD      = 2'd2,
    OP_RESAMPLE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PHI_WR,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_SCORE,
    ST_MUL,
    ST_SEL,
    ST_INC_RD,
    ST_INC_WR
  } state_e;

  typedef struct packed {
    logic accept;
    logic phi_wr;
    logic clear_step;
    logic dec_rd;
    logic dec_wr;
    logic score_issue;
    logic mul_step;
    logic sel_issue;
    logic inc_wr;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic score_done;
    logic mul_last;
    logic target_zero;
    logic sel_done;
  } sts_t;

endpackage

// File: hdl/lgts_ram.sv
// ----------------------------------------------------------------------------
// lgts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lgts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lgts_ctrl.sv
// ----------------------------------------------------------------------------
// lgts_ctrl
// Sequencer of the topic sampler: steps the datapath through clearing,
// phi loads, count updates and the score, scale and select passes.
// ----------------------------------------------------------------------------
module lgts_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lgts_pkg::OP_W-1:0]   op_i,
  input  lgts_pkg::sts_t              sts_i,
  output lgts_pkg::cmd_t              cmd_o,
  output logic                        busy_o
);

  lgts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgts_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lgts_pkg::ST_CLEAR: begin
        if (sts_i.clear_last) state_d = lgts_pkg::ST_IDLE;
      end
      lgts_pkg::ST_IDLE: begin
        if (start_i) begin
          case (lgts_pkg::op_e'(op_i))
            lgts_pkg::OP_LOAD:     state_d = lgts_pkg::ST_PHI_WR;
            lgts_pkg::OP_CLEAR:    state_d = lgts_pkg::ST_CLEAR;
            lgts_pkg::OP_ADD:      state_d = lgts_pkg::ST_INC_RD;
            lgts_pkg::OP_RESAMPLE: state_d = lgts_pkg::ST_DEC_RD;
            default:               state_d = lgts_pkg::ST_IDLE;
          endcase
        end
      end
      lgts_pkg::ST_PHI_WR: state_d = lgts_pkg::ST_IDLE;
      lgts_pkg::ST_DEC_RD: state_d = lgts_pkg::ST_DEC_WR;
      lgts_pkg::ST_DEC_WR: state_d = lgts_pkg::ST_SCORE;
      lgts_pkg::ST_SCORE: begin
        if (sts_i.score_done) state_d = lgts_pkg::ST_MUL;
      end
      lgts_pkg::ST_MUL: begin
        if (sts_i.mul_last) state_d = lgts_pkg::ST_SEL;
      end
      lgts_pkg::ST_SEL: begin
        if (sts_i.target_zero || sts_i.sel_done) state_d = lgts_pkg::ST_INC_RD;
      end
      lgts_pkg::ST_INC_RD: state_d = lgts_pkg::ST_INC_WR;
      lgts_pkg::ST_INC_WR: state_d = lgts_pkg::ST_IDLE;
      default:             state_d = lgts_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      lgts_pkg::ST_CLEAR: cmd_o.clear_step = 1'b1;
      lgts_pkg::ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      lgts_pkg::ST_PHI_WR: cmd_o.phi_wr      = 1'b1;
      lgts_pkg::ST_DEC_RD: cmd_o.dec_rd      = 1'b1;
      lgts_pkg::ST_DEC_WR: cmd_o.dec_wr      = 1'b1;
      lgts_pkg::ST_SCORE:  cmd_o.score_issue = 1'b1;
      lgts_pkg::ST_MUL:    cmd_o.mul_step    = 1'b1;
      lgts_pkg::ST_SEL:    cmd_o.sel_issue   = 1'b1;
      lgts_pkg::ST_INC_RD: cmd_o             = '0;
      lgts_pkg::ST_INC_WR: cmd_o.inc_wr      = 1'b1;
      default:             cmd_o             = '0;
    endcase
  end

endmodule

// File: hdl/lgts_dp.sv
// ----------------------------------------------------------------------------
// lgts_dp
// Datapath of the topic sampler: phi, count and score memories, the score
// pipeline, the shift-add draw scaler and the running-sum selector.
// ----------------------------------------------------------------------------
module lgts_dp #(
  parameter int unsigned MAX_TOPICS = 64,
  parameter int unsigned VOCAB_SIZE = 4096,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lgts_pkg::cmd_t                   cmd_i,
  output lgts_pkg::sts_t                   sts_o,
  input  logic [lgts_pkg::OP_W-1:0]        op_i,
  input  logic [lgts_pkg::WORD_W-1:0]      word_i,
  input  logic [lgts_pkg::TOPIC_W-1:0]     topic_i,
  input  logic [lgts_pkg::PHI_W-1:0]       phi_value_i,
  input  logic [lgts_pkg::DRAW_W-1:0]      random_draw_i,
  input  logic                             cfg_we_i,
  input  logic [lgts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lgts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [lgts_pkg::TOPIC_W-1:0]     new_topic_o,
  output logic                             done_o
);

  localparam int unsigned TW        = $clog2(MAX_TOPICS);
  localparam int unsigned NW        = $clog2(MAX_TOPICS + 1);
  localparam int unsigned PHI_DEPTH = MAX_TOPICS * VOCAB_SIZE;
  localparam int unsigned PA_W      = $clog2(PHI_DEPTH);
  localparam int unsigned CW        = COUNT_BITS;
  localparam int unsigned BASE_W    =
    ((CW + 8 > lgts_pkg::ALPHA_W) ? CW + 8 : lgts_pkg::ALPHA_W) + 1;
  localparam int unsigned SCORE_W   = BASE_W + lgts_pkg::PHI_W;
  localparam int unsigned SUM_W     = SCORE_W + TW;
  localparam int unsigned ACC_W     = SUM_W + lgts_pkg::DRAW_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // configuration
  logic [lgts_pkg::ALPHA_W-1:0] alpha_q;
  logic [lgts_pkg::NTOP_W-1:0]  ntop_q;
  logic [NW-1:0]                n_eff, n_last;

  // latched item
  lgts_pkg::op_e                op_q, op_d;
  logic [lgts_pkg::WORD_W-1:0]  word_q, word_d;
  logic [lgts_pkg::TOPIC_W-1:0] topic_q, topic_d;
  logic [lgts_pkg::PHI_W-1:0]   phi_q, phi_d;
  logic [lgts_pkg::DRAW_W-1:0]  dsh_q, dsh_d;
  logic                         word_ok, topic_ok;

  // sequencing
  logic [NW-1:0]                k_q, k_d;
  logic [lgts_pkg::MCNT_W-1:0]  mcnt_q, mcnt_d;
  logic [PA_W:0]                pbase_q, pbase_d;
  logic                         score_go, sel_go;

  // score pipeline
  logic                         s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic [TW-1:0]                s1_idx_q, s1_idx_d, s2_idx_q, s2_idx_d;
  logic [SCORE_W-1:0]           prod_q, prod_d;
  logic [BASE_W-1:0]            base;
  logic [lgts_pkg::PHI_W-1:0]   phi_eff;
  logic [SUM_W-1:0]             sum_q, sum_d;

  // scaling and selection
  logic [ACC_W-1:0]             acc_q, acc_d;
  logic [SUM_W-1:0]             target;
  logic                         target_zero;
  logic                         t1_v_q, t1_v_d;
  logic [TW-1:0]                t1_idx_q, t1_idx_d;
  logic [SUM_W-1:0]             run_q, run_d, run_new;
  logic                         hit, at_last, sel_eval;
  logic [TW-1:0]                pick_q, pick_d;

  // memories
  logic                         phi_we;
  logic [PA_W-1:0]              phi_waddr;
  logic [lgts_pkg::PHI_W-1:0]   phi_rdata;
  logic                         cnt_we;
  logic [TW-1:0]                cnt_waddr, cnt_raddr, inc_addr;
  logic [CW-1:0]                cnt_wdata, cnt_rdata;
  logic [SCORE_W-1:0]           score_rdata;

  // result
  logic                         done_q, done_d;
  logic [lgts_pkg::TOPIC_W-1:0] new_topic_q, new_topic_d;

  // topics in use, clamped to [1, MAX_TOPICS]
  always_comb begin
    if (ntop_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(ntop_q) > MAX_TOPICS) begin
      n_eff = NW'(MAX_TOPICS);
    end else begin
      n_eff = NW'(ntop_q);
    end
  end
  assign n_last = n_eff - NW'(1);

  assign word_ok  = 32'(word_q) < VOCAB_SIZE;
  assign topic_ok = 32'(topic_q) < MAX_TOPICS;

  assign score_go = cmd_i.score_issue && (k_q < n_eff);
  assign target   = acc_q[ACC_W-1:lgts_pkg::DRAW_W];
  assign target_zero = (target == '0);
  assign sel_go   = cmd_i.sel_issue && !target_zero && (k_q < n_eff);

  assign phi_eff = word_ok ? phi_rdata : '0;
  assign base    = BASE_W'({cnt_rdata, 8'd0}) + BASE_W'(alpha_q);

  assign run_new  = run_q + SUM_W'(score_rdata);
  assign hit      = run_new >= target;
  assign at_last  = NW'(t1_idx_q) == n_last;
  assign sel_eval = cmd_i.sel_issue && !target_zero && t1_v_q;

  assign inc_addr = (op_q == lgts_pkg::OP_ADD) ? TW'(topic_q) : pick_q;

  always_comb begin
    op_d     = op_q;
    word_d   = word_q;
    topic_d  = topic_q;
    phi_d    = phi_q;
    dsh_d    = dsh_q;
    k_d      = k_q;
    mcnt_d   = mcnt_q;
    pbase_d  = pbase_q;
    sum_d    = sum_q;
    acc_d    = acc_q;
    run_d    = run_q;
    pick_d   = pick_q;

    if (cmd_i.accept) begin
      op_d    = lgts_pkg::op_e'(op_i);
      word_d  = word_i;
      topic_d = topic_i;
      phi_d   = phi_value_i;
      dsh_d   = random_draw_i;
      k_d     = '0;
      mcnt_d  = '0;
      pbase_d = (PA_W + 1)'(word_i);
      sum_d   = '0;
      acc_d   = '0;
      run_d   = '0;
      pick_d  = '0;
    end

    if (cmd_i.clear_step) begin
      k_d = k_q + NW'(1);
    end

    // score pass: read count and phi, multiply, accumulate
    s1_v_d   = score_go;
    s1_idx_d = k_q[TW-1:0];
    if (score_go) begin
      k_d     = k_q + NW'(1);
      pbase_d = pbase_q + (PA_W + 1)'(VOCAB_SIZE);
    end
    s2_v_d   = s1_v_q;
    s2_idx_d = s1_idx_q;
    prod_d   = SCORE_W'(base) * SCORE_W'(phi_eff);
    if (s2_v_q) begin
      sum_d = sum_q + SUM_W'(prod_q);
    end

    // target = floor(sum * draw / 2^16), one draw bit a cycle
    if (cmd_i.mul_step) begin
      acc_d  = {acc_q[ACC_W-2:0], 1'b0}
             + (dsh_q[lgts_pkg::DRAW_W-1] ? ACC_W'(sum_q) : '0);
      dsh_d  = {dsh_q[lgts_pkg::DRAW_W-2:0], 1'b0};
      mcnt_d = mcnt_q + lgts_pkg::MCNT_W'(1);
      k_d    = '0;
    end

    // select pass: first running sum that reaches the target, else the last topic in use
    t1_v_d   = sel_go;
    t1_idx_d = k_q[TW-1:0];
    if (sel_go) begin
      k_d = k_q + NW'(1);
    end
    if (sel_eval) begin
      if (hit) begin
        pick_d = t1_idx_q;
      end else begin
        run_d = run_new;
        if (at_last) pick_d = TW'(n_last);
      end
    end
  end

  // count memory ports
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = inc_addr;
    cnt_wdata = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + CW'(1);
    if (cmd_i.clear_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = k_q[TW-1:0];
      cnt_wdata = '0;
    end else if (cmd_i.dec_wr) begin
      cnt_we    = topic_ok && (cnt_rdata != '0);
      cnt_waddr = TW'(topic_q);
      cnt_wdata = cnt_rdata - CW'(1);
    end else if (cmd_i.inc_wr) begin
      cnt_we    = (op_q != lgts_pkg::OP_ADD) || topic_ok;
    end
  end

  assign cnt_raddr = score_go     ? k_q[TW-1:0] :
                     cmd_i.dec_rd ? TW'(topic_q) : inc_addr;

  assign phi_we    = cmd_i.phi_wr && topic_ok && word_ok;
  assign phi_waddr = PA_W'(32'(topic_q) * VOCAB_SIZE + 32'(word_q));

  assign done_d      = cmd_i.inc_wr && (op_q == lgts_pkg::OP_RESAMPLE);
  assign new_topic_d = done_d ? lgts_pkg::TOPIC_W'(pick_q) : new_topic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= lgts_pkg::ALPHA_RESET;
      ntop_q  <= lgts_pkg::NTOP_RESET;
      k_q     <= '0;
      mcnt_q  <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      t1_v_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == lgts_pkg::CFG_ALPHA)) begin
        alpha_q <= cfg_data_i[lgts_pkg::ALPHA_W-1:0];
      end
      if (cfg_we_i && (cfg_index_i == lgts_pkg::CFG_TOPICS)) begin
        ntop_q <= cfg_data_i[lgts_pkg::NTOP_W-1:0];
      end
      k_q    <= k_d;
      mcnt_q <= mcnt_d;
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      t1_v_q <= t1_v_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    word_q      <= word_d;
    topic_q     <= topic_d;
    phi_q       <= phi_d;
    dsh_q       <= dsh_d;
    pbase_q     <= pbase_d;
    s1_idx_q    <= s1_idx_d;
    s2_idx_q    <= s2_idx_d;
    prod_q      <= prod_d;
    sum_q       <= sum_d;
    acc_q       <= acc_d;
    t1_idx_q    <= t1_idx_d;
    run_q       <= run_d;
    pick_q      <= pick_d;
    new_topic_q <= new_topic_d;
  end

  lgts_ram #(
    .WIDTH (lgts_pkg::PHI_W),
    .DEPTH (PHI_DEPTH)
  ) u_phi_ram (
    .clk_i   (clk_i),
    .we_i    (phi_we),
    .waddr_i (phi_waddr),
    .wdata_i (phi_q),
    .raddr_i (pbase_q[PA_W-1:0]),
    .rdata_o (phi_rdata)
  );

  lgts_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_TOPICS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  lgts_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_TOPICS)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (s2_v_q),
    .waddr_i (s2_idx_q),
    .wdata_i (prod_q),
    .raddr_i (k_q[TW-1:0]),
    .rdata_o (score_rdata)
  );

  assign sts_o.clear_last  = (k_q == NW'(MAX_TOPICS - 1));
  assign sts_o.score_done  = (k_q >= n_eff) && !s1_v_q && !s2_v_q;
  assign sts_o.mul_last    = (mcnt_q == lgts_pkg::MCNT_W'(lgts_pkg::DRAW_W - 1));
  assign sts_o.target_zero = target_zero;
  assign sts_o.sel_done    = sel_eval && (hit || at_last);

  assign done_o      = done_q;
  assign new_topic_o = new_topic_q;

  a_done_after_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.inc_wr))
    else $error("result strobe without a count update");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (NW'(pick_q) < n_eff))
    else $error("picked topic outside the topics in use");

  a_score_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> $past(s1_v_q))
    else $error("score stage two valid without stage one");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_eval |-> (run_q <= sum_q))
    else $error("running sum exceeds score total");

endmodule

// File: hdl/lda_gibbs_topic_sampler_unit.sv
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler_unit
// Gibbs topic resampler for one document with a fixed topic-word table.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. A resample (op 3)
// decrements the old topic's count with a read and a write, scores the
// topics in use one per cycle through the phi and count memories, drains the
// score pipeline, scales the draw by the score total with a shift-add over
// the 16 draw bits, walks the stored scores one topic per cycle up to the
// pick and increments the picked topic's count with a read and a write. The
// result shows on new_topic_o with done_o high for exactly one cycle, in the
// first cycle that busy_o is low again, and cannot be held off; new_topic_o
// then holds it. A phi load is a single write, an initial assignment a count
// read and write, and a count clear zeroes all MAX_TOPICS counts; so does
// reset, with busy_o high. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module lda_gibbs_topic_sampler_unit #(
  parameter int unsigned MAX_TOPICS = 64,
  parameter int unsigned VOCAB_SIZE = 4096,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [lgts_pkg::OP_W-1:0]        op_i,
  input  logic [lgts_pkg::WORD_W-1:0]      word_i,
  input  logic [lgts_pkg::TOPIC_W-1:0]     topic_i,
  input  logic [lgts_pkg::PHI_W-1:0]       phi_value_i,
  input  logic [lgts_pkg::DRAW_W-1:0]      random_draw_i,
  output logic [lgts_pkg::TOPIC_W-1:0]     new_topic_o,
  output logic                             done_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lgts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lgts_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  lgts_pkg::cmd_t cmd;
  lgts_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  lgts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  lgts_dp #(
    .MAX_TOPICS (MAX_TOPICS),
    .VOCAB_SIZE (VOCAB_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .word_i        (word_i),
    .topic_i       (topic_i),
    .phi_value_i   (phi_value_i),
    .random_draw_i (random_draw_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .new_topic_o   (new_topic_o),
    .done_o        (done_o)
  );

endmodule
